/* rtl/core/rdrt_pkg.sv */
// shared types and constants of the rpc duplicate request table
package rdrt_pkg;

    localparam int unsigned RDRT_TABLE_ENTRIES = 128;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CALL_W   = 8;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned S_DATA_W = 168;
    localparam int unsigned M_DATA_W = 168;
    localparam int unsigned M_USER_W = 3;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_DONE    = 1'b1;

    typedef enum logic [1:0] {
        CELL_NOP,
        CELL_INSERT,
        CELL_SEQ,
        CELL_DONE
    } t_cell_op;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cell_op            op;
        logic [DATA_W-1:0]   seq;
        logic [DATA_W-1:0]   result;
    } t_cell_cmd;

    // contents of one slot, handed down the row on insert
    typedef struct packed {
        logic                valid;
        logic [DATA_W-1:0]   client;
        logic [DATA_W-1:0]   last_seq;
        logic [DATA_W-1:0]   result;
        logic                done;
    } t_slot;

    // what the lookup found for the current item
    typedef struct packed {
        logic                found;
        logic [DATA_W-1:0]   last_seq;
        logic [DATA_W-1:0]   result;
        logic                done;
    } t_lookup;

endpackage

/* rtl/core/rdrt_cell.sv */
// one table slot: client match, in-place update and shift on insert
module rdrt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rdrt_pkg::t_cell_cmd i_cmd,
    input  rdrt_pkg::t_slot    i_prev,
    input  logic [rdrt_pkg::DATA_W-1:0] i_key,
    input  logic               i_match_en,
    output rdrt_pkg::t_slot    o_slot,
    output logic               o_hit
);

    logic                        r_valid;
    logic [rdrt_pkg::DATA_W-1:0] r_client;
    logic [rdrt_pkg::DATA_W-1:0] r_last_seq;
    logic [rdrt_pkg::DATA_W-1:0] r_result;
    logic                        r_done;
    logic                        r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmd.op == rdrt_pkg::CELL_INSERT) begin
                r_valid <= i_prev.valid;
            end
            if (i_match_en) begin
                r_hit <= r_valid && (r_client == i_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rdrt_pkg::CELL_INSERT: begin
                r_client   <= i_prev.client;
                r_last_seq <= i_prev.last_seq;
                r_result   <= i_prev.result;
                r_done     <= i_prev.done;
            end
            rdrt_pkg::CELL_SEQ: begin
                if (r_hit) begin
                    r_last_seq <= i_cmd.seq;
                    r_done     <= 1'b0;
                end
            end
            rdrt_pkg::CELL_DONE: begin
                if (r_hit) begin
                    r_result <= i_cmd.result;
                    r_done   <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_slot.valid    = r_valid;
    assign o_slot.client   = r_client;
    assign o_slot.last_seq = r_last_seq;
    assign o_slot.result   = r_result;
    assign o_slot.done     = r_done;
    assign o_hit           = r_hit;

endmodule

/* rtl/core/rdrt_collect.sv */
// gathers the fields of the single matching slot into a register
module rdrt_collect #(
    parameter int unsigned TABLE_ENTRIES = rdrt_pkg::RDRT_TABLE_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  rdrt_pkg::t_slot    i_slots [TABLE_ENTRIES],
    input  logic [TABLE_ENTRIES-1:0] i_hits,
    output rdrt_pkg::t_lookup  o_lookup
);

    rdrt_pkg::t_lookup n_lookup;
    rdrt_pkg::t_lookup r_lookup;

    // at most one slot hits, so an or of the gated slots selects it
    always_comb begin
        n_lookup       = '0;
        n_lookup.found = |i_hits;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i_hits[i]) begin
                n_lookup.last_seq = n_lookup.last_seq | i_slots[i].last_seq;
                n_lookup.result   = n_lookup.result | i_slots[i].result;
                n_lookup.done     = n_lookup.done | i_slots[i].done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lookup <= n_lookup;
        end
    end

    assign o_lookup = r_lookup;

endmodule

/* rtl/core/rpc_duplicate_request_table_unit.sv */
// top level: controller, row of slot cells and lookup register
//
//  channel | dir | tdata (low bit up)                                   | tuser
//  s_axis  | in  | client, sequence, opcode, arg_first,                 | command
//          |     | arg_second, done_value                               |
//  m_axis  | out | reply_client, reply_seq, reply_call, reply_value,    | reply_kind,
//          |     | dispatch_arg_first, dispatch_arg_second              | dispatch
//
// each word passes four steps: accept, parallel client compare in every cell,
// registered gather of the hit slot, then decision with table update.
// a new client is shifted into the first cell, older slots move one cell down.
// reset clears the slot valid bits and the fill count.
// a result waiting on m_axis holds the decision step, input waits meanwhile.
module rpc_duplicate_request_table_unit #(
    parameter int unsigned TABLE_ENTRIES = rdrt_pkg::RDRT_TABLE_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // client, sequence, opcode, arg_first, arg_second, done_value
    input  logic [rdrt_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // command
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // reply_client, reply_seq, reply_call, reply_value,
    // dispatch_arg_first, dispatch_arg_second
    output logic [rdrt_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    // reply_kind, dispatch
    output logic [rdrt_pkg::M_USER_W-1:0]   o_m_axis_tuser
);

    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned DW    = rdrt_pkg::DATA_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_READ,
        S_EXEC
    } t_state;

    t_state r_state;

    logic                         r_cmd;
    logic [DW-1:0]                r_client;
    logic [DW-1:0]                r_seq;
    logic [rdrt_pkg::CALL_W-1:0]  r_call;
    logic [DW-1:0]                r_arg_first;
    logic [DW-1:0]                r_arg_second;
    logic [DW-1:0]                r_done_value;
    logic [CNT_W-1:0]             r_fill;

    logic                         r_out_valid;
    logic [rdrt_pkg::KIND_W-1:0]  r_out_kind;
    logic [DW-1:0]                r_out_client;
    logic [DW-1:0]                r_out_seq;
    logic [rdrt_pkg::CALL_W-1:0]  r_out_call;
    logic [DW-1:0]                r_out_value;
    logic                         r_out_dispatch;
    logic [DW-1:0]                r_out_arg_first;
    logic [DW-1:0]                r_out_arg_second;

    rdrt_pkg::t_slot    w_slots [TABLE_ENTRIES];
    rdrt_pkg::t_slot    w_new_slot;
    logic [TABLE_ENTRIES-1:0] w_hits;
    rdrt_pkg::t_lookup  w_lookup;
    rdrt_pkg::t_cell_cmd w_cmd;

    logic                         n_has_out;
    logic [rdrt_pkg::KIND_W-1:0]  n_kind;
    logic                         n_dispatch;
    logic [DW-1:0]                n_value;
    rdrt_pkg::t_cell_op           n_op;
    logic [DW-1:0]                n_ins_seq;
    logic                         w_out_free;
    logic                         w_commit;
    logic                         w_full;
    logic                         w_seq_gt;
    logic                         w_seq_eq;
    logic                         w_new_gt;
    logic                         w_new_eq;

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_commit   = (r_state == S_EXEC) && w_out_free;
    assign w_full     = (r_fill == CNT_W'(TABLE_ENTRIES));
    assign w_seq_gt   = $signed(r_seq) > $signed(w_lookup.last_seq);
    assign w_seq_eq   = r_seq == w_lookup.last_seq;
    assign w_new_gt   = $signed(r_seq) > $signed(DW'(0));
    assign w_new_eq   = r_seq == '0;

    // decision for the current word from the gathered slot
    always_comb begin
        n_has_out  = 1'b0;
        n_kind     = rdrt_pkg::KIND_ACK;
        n_dispatch = 1'b0;
        n_value    = '0;
        n_op       = rdrt_pkg::CELL_NOP;
        n_ins_seq  = '0;
        if (r_cmd == rdrt_pkg::CMD_DONE) begin
            if (w_lookup.found && w_seq_eq) begin
                n_op = rdrt_pkg::CELL_DONE;
            end
        end else if (!w_lookup.found) begin
            if (w_full) begin
                n_has_out = 1'b1;
                n_kind    = rdrt_pkg::KIND_FULL;
            end else begin
                n_op = rdrt_pkg::CELL_INSERT;
                // fresh slot starts at sequence zero, then takes a higher one
                if (w_new_gt) begin
                    n_ins_seq  = r_seq;
                    n_has_out  = 1'b1;
                    n_dispatch = 1'b1;
                end else if (w_new_eq) begin
                    n_has_out = 1'b1;
                end
            end
        end else begin
            if (w_seq_gt) begin
                n_op       = rdrt_pkg::CELL_SEQ;
                n_has_out  = 1'b1;
                n_dispatch = 1'b1;
            end else if (w_seq_eq) begin
                n_has_out = 1'b1;
                if (w_lookup.done) begin
                    n_kind  = rdrt_pkg::KIND_VALUE;
                    n_value = w_lookup.result;
                end
            end
        end
    end

    assign w_cmd.op     = w_commit ? n_op : rdrt_pkg::CELL_NOP;
    assign w_cmd.seq    = r_seq;
    assign w_cmd.result = r_done_value;

    assign w_new_slot.valid    = 1'b1;
    assign w_new_slot.client   = r_client;
    assign w_new_slot.last_seq = n_ins_seq;
    assign w_new_slot.result   = '0;
    assign w_new_slot.done     = 1'b0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        rdrt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_prev     ((g == 0) ? w_new_slot : w_slots[(g == 0) ? 0 : g - 1]),
            .i_key      (r_client),
            .i_match_en (r_state == S_MATCH),
            .o_slot     (w_slots[g]),
            .o_hit      (w_hits[g])
        );
    end

    rdrt_collect #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_collect (
        .i_clk    (i_clk),
        .i_en     (r_state == S_READ),
        .i_slots  (w_slots),
        .i_hits   (w_hits),
        .o_lookup (w_lookup)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        if (n_op == rdrt_pkg::CELL_INSERT) begin
                            r_fill <= r_fill + CNT_W'(1);
                        end
                        if (n_has_out) begin
                            r_out_valid      <= 1'b1;
                            r_out_kind       <= n_kind;
                            r_out_client     <= r_client;
                            r_out_seq        <= r_seq;
                            r_out_call       <= r_call;
                            r_out_value      <= n_value;
                            r_out_dispatch   <= n_dispatch;
                            r_out_arg_first  <= n_dispatch ? r_arg_first : '0;
                            r_out_arg_second <= n_dispatch ? r_arg_second : '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_cmd        <= i_s_axis_tuser;
            r_client     <= i_s_axis_tdata[31:0];
            r_seq        <= i_s_axis_tdata[63:32];
            r_call       <= i_s_axis_tdata[71:64];
            r_arg_first  <= i_s_axis_tdata[103:72];
            r_arg_second <= i_s_axis_tdata[135:104];
            r_done_value <= i_s_axis_tdata[167:136];
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_arg_second, r_out_arg_first, r_out_value,
                              r_out_call, r_out_seq, r_out_client};
    assign o_m_axis_tuser  = {r_out_dispatch, r_out_kind};

endmodule

/* tb/tb_top.sv */
// testbench for the duplicate request table: random request and completion traffic, scoreboard
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS        = rdrt_pkg::RDRT_TABLE_ENTRIES;
    localparam int POOL         = 40;
    localparam int RANDOM_WORDS = 930;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic              cmd;
        logic [31:0]       client;
        logic [31:0]       seq_num;
        logic [7:0]        opcode;
        logic [31:0]       arg_a;
        logic [31:0]       arg_b;
        logic [31:0]       done_val;
    } t_req_word;

    typedef struct packed {
        logic [rdrt_pkg::KIND_W-1:0] kind;
        logic [31:0]       client;
        logic [31:0]       seq_num;
        logic [7:0]        opcode;
        logic [31:0]       result;
        logic              dispatch;
        logic [31:0]       disp_a;
        logic [31:0]       disp_b;
    } t_reply_word;

    // per-client table that predicts the reply to every accepted word
    class t_dedup_table;
        logic [31:0]   slot_client [SLOTS];
        logic [31:0]   slot_seq [SLOTS];
        logic [31:0]   slot_result [SLOTS];
        bit            slot_done [SLOTS];
        int            used_slots;
        t_reply_word   replies_due [$];
        int            errors;

        function int find_client(logic [31:0] client);
            for (int i = 0; i < used_slots; i++)
                if (slot_client[i] == client) return i;
            return -1;
        endfunction

        function void take_word(t_req_word w);
            t_reply_word r;
            int hit;
            hit = find_client(w.client);
            if (w.cmd == rdrt_pkg::CMD_DONE) begin
                if (hit >= 0 && slot_seq[hit] == w.seq_num) begin
                    slot_result[hit] = w.done_val;
                    slot_done[hit] = 1'b1;
                end
                return;
            end
            r = '0;
            r.kind = rdrt_pkg::KIND_ACK;
            r.client = w.client;
            r.seq_num = w.seq_num;
            r.opcode = w.opcode;
            if (hit < 0) begin
                if (used_slots >= SLOTS) begin
                    r.kind = rdrt_pkg::KIND_FULL;
                    replies_due.push_back(r);
                    return;
                end
                hit = used_slots;
                slot_client[hit] = w.client;
                slot_seq[hit] = '0;
                slot_result[hit] = '0;
                slot_done[hit] = 1'b0;
                used_slots++;
            end
            if ($signed(w.seq_num) > $signed(slot_seq[hit])) begin
                slot_seq[hit] = w.seq_num;
                slot_done[hit] = 1'b0;
                r.dispatch = 1'b1;
                r.disp_a = w.arg_a;
                r.disp_b = w.arg_b;
                replies_due.push_back(r);
            end else if (w.seq_num == slot_seq[hit]) begin
                if (slot_done[hit]) begin
                    r.kind = rdrt_pkg::KIND_VALUE;
                    r.result = slot_result[hit];
                end
                replies_due.push_back(r);
            end
        endfunction

        function void check_reply(t_reply_word got);
            t_reply_word want;
            if (replies_due.size() == 0) begin
                $error("reply with nothing expected: kind %0d client %h seq %h",
                       got.kind, got.client, got.seq_num);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (got.kind != want.kind) begin
                $error("reply_kind expected %0d got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.client != want.client) begin
                $error("reply_client expected %h got %h", want.client, got.client);
                errors++;
            end
            if (got.seq_num != want.seq_num) begin
                $error("reply_seq expected %h got %h", want.seq_num, got.seq_num);
                errors++;
            end
            if (got.opcode != want.opcode) begin
                $error("reply_call expected %h got %h", want.opcode, got.opcode);
                errors++;
            end
            if (got.result != want.result) begin
                $error("reply_value expected %h got %h", want.result, got.result);
                errors++;
            end
            if (got.dispatch != want.dispatch) begin
                $error("dispatch expected %0d got %0d", want.dispatch, got.dispatch);
                errors++;
            end
            if (got.disp_a != want.disp_a) begin
                $error("dispatch_arg_first expected %h got %h", want.disp_a, got.disp_a);
                errors++;
            end
            if (got.disp_b != want.disp_b) begin
                $error("dispatch_arg_second expected %h got %h", want.disp_b, got.disp_b);
                errors++;
            end
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic [rdrt_pkg::S_DATA_W-1:0]   in_data = '0;
    logic                            in_cmd = rdrt_pkg::CMD_REQUEST;
    logic                            out_ready = 1'b0;
    logic                            in_ready;
    logic                            out_valid;
    logic [rdrt_pkg::M_DATA_W-1:0]   out_data;
    logic [rdrt_pkg::M_USER_W-1:0]   out_user;

    t_dedup_table dup_model = new();
    int          words_sent = 0;
    bit          calm = 1'b0;
    int          idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    rpc_duplicate_request_table_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_cmd),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_user)
    );

    // monitor both sides and watch for lack of progress
    always @(posedge i_clk) begin
        t_reply_word got;
        t_req_word   seen;
        if (out_valid && out_ready) begin
            got.client    = out_data[31:0];
            got.seq_num   = out_data[63:32];
            got.opcode    = out_data[71:64];
            got.result    = out_data[103:72];
            got.disp_a    = out_data[135:104];
            got.disp_b    = out_data[167:136];
            got.kind      = out_user[1:0];
            got.dispatch  = out_user[2];
            dup_model.check_reply(got);
        end
        if (in_valid && in_ready && i_rst_n) begin
            seen.cmd       = in_cmd;
            seen.client    = in_data[31:0];
            seen.seq_num   = in_data[63:32];
            seen.opcode    = in_data[71:64];
            seen.arg_a     = in_data[103:72];
            seen.arg_b     = in_data[135:104];
            seen.done_val  = in_data[167:136];
            dup_model.take_word(seen);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off so the table backs up
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && words_sent >= 150) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_ready <= calm || ($urandom_range(99) >= 12);
        end
    end

    task automatic send_word(input t_req_word w);
        while (!calm && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= w.cmd;
        in_data  <= {w.done_val, w.arg_b, w.arg_a, w.opcode, w.seq_num, w.client};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_req(input logic [31:0] client, input logic [31:0] seq_num,
                            input logic [7:0] opcode, input logic [31:0] arg_a,
                            input logic [31:0] arg_b);
        t_req_word w;
        w = '{rdrt_pkg::CMD_REQUEST, client, seq_num, opcode, arg_a, arg_b, $urandom};
        send_word(w);
    endtask

    task automatic send_done(input logic [31:0] client, input logic [31:0] seq_num,
                             input logic [31:0] done_val);
        t_req_word w;
        w = '{rdrt_pkg::CMD_DONE, client, seq_num, 8'($urandom), $urandom, $urandom,
              done_val};
        send_word(w);
    endtask

    initial begin
        logic [31:0] pool_client [POOL];
        logic [31:0] pool_seq [POOL];
        t_req_word   w;
        int          r;
        int          k;

        for (int i = 0; i < POOL; i++) begin
            pool_client[i] = $urandom;
            pool_seq[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first contact, duplicates, stale, completions, extremes
        send_req(32'h0000_0001, 32'h0, 8'h00, 32'h0, 32'h0);
        send_req(32'h0000_0001, 32'h1, 8'hFF, 32'hFFFF_FFFF, 32'h0);
        send_req(32'h0000_0001, 32'h1, 8'hFF, 32'h0, 32'h0);
        send_done(32'h0000_0001, 32'h0, 32'h5);
        send_done(32'h0000_0001, 32'h1, 32'hFFFF_FFFF);
        send_req(32'h0000_0001, 32'h1, 8'h11, 32'h1, 32'h2);
        send_req(32'h0000_0001, 32'h0, 8'h22, 32'h1, 32'h2);
        send_req(32'h0000_0001, 32'h8000_0000, 8'h33, 32'h1, 32'h2);
        send_done(32'h8000_0000, 32'h0, 32'h1);
        send_req(32'h8000_0000, 32'h7FFF_FFFF, 8'hA5, 32'h8000_0000, 32'h7FFF_FFFF);
        send_req(32'h8000_0000, 32'h7FFF_FFFF, 8'h5A, 32'h0, 32'h0);
        send_done(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_req(32'h8000_0000, 32'h7FFF_FFFF, 8'h01, 32'h0, 32'h0);
        send_req(32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'h02, 32'h3, 32'h4);
        send_req(32'h7FFF_FFFF, 32'h0, 8'h03, 32'h3, 32'h4);
        send_done(32'h7FFF_FFFF, 32'h0, 32'h0000_1234);
        send_req(32'h7FFF_FFFF, 32'h0, 8'h04, 32'h3, 32'h4);
        // a higher sequence after completion clears the stored result
        send_req(32'h0000_0001, 32'h2, 8'h5A, 32'h5555_5555, 32'hAAAA_AAAA);
        send_req(32'h0000_0001, 32'h2, 8'hA5, 32'hAAAA_AAAA, 32'h5555_5555);
        send_req(32'h0000_0000, 32'h0, 8'h00, 32'h0, 32'h0);
        send_req(32'hFFFF_FFFF, 32'h1, 8'h80, 32'h7FFF_FFFF, 32'h8000_0000);
        send_done(32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF);
        send_req(32'hFFFF_FFFF, 32'h1, 8'h7F, 32'h0, 32'h0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= 300 && n < 440);
            k = $urandom_range(POOL - 1);
            r = $urandom_range(99);
            if (n >= 520 && n < 670) begin
                // fresh clients until the table overflows
                send_req($urandom, 32'($urandom_range(3)), 8'($urandom), $urandom, $urandom);
            end else if (r < 35) begin
                if ($urandom_range(9) == 0)
                    pool_seq[k] = pool_seq[k] + $urandom_range(1, 1 << 20);
                else
                    pool_seq[k] = pool_seq[k] + $urandom_range(1, 3);
                send_req(pool_client[k], pool_seq[k], 8'($urandom), $urandom, $urandom);
            end else if (r < 55) begin
                send_done(pool_client[k], pool_seq[k], $urandom);
            end else if (r < 72) begin
                send_req(pool_client[k], pool_seq[k], 8'($urandom), $urandom, $urandom);
            end else if (r < 78) begin
                send_req(pool_client[k], pool_seq[k] - $urandom_range(1, 4), 8'($urandom),
                         $urandom, $urandom);
            end else if (r < 83) begin
                send_done(pool_client[k], pool_seq[k] + $urandom_range(1, 4), $urandom);
            end else if (r < 90) begin
                send_done($urandom, $urandom, $urandom);
            end else begin
                w = {1'($urandom), $urandom, $urandom, 8'($urandom), $urandom, $urandom,
                     $urandom};
                send_word(w);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (dup_model.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (dup_model.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
